### rtl/hbs_pkg.sv
// shared types and constants for the heightmap bilinear sampler
// used by hbs_store and heightmap_bilinear_sampler_top; no dependencies
package hbs_pkg;

	// store geometry
	localparam int unsigned STORE_DEPTH = 65536;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

	// field widths
	localparam int unsigned RAW_W   = 16;
	localparam int unsigned COORD_W = 20;
	localparam int unsigned HGT_W   = 25;

	// request kinds carried on tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_BEYOND  = 2'd2;

	// register indexes on the configuration port
	localparam logic [1:0] REG_MAP_WIDTH = 2'd0;
	localparam logic [1:0] REG_CELLS     = 2'd1;
	localparam logic [1:0] REG_LIMIT     = 2'd2;

	// register reset values
	localparam logic [10:0] MAP_WIDTH_RST = 11'd256;
	localparam logic [23:0] CELLS_RST     = 24'd65536;
	localparam logic [18:0] LIMIT_RST     = 19'd65024;

	// 20480 in units of 2^-8
	localparam logic [HGT_W-1:0] HEIGHT_BIAS = 25'd5242880;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [RAW_W-1:0]  raw_t;

endpackage

### rtl/hbs_store.sv
// height sample store: two copies, each with two registered read ports
// depends on hbs_pkg
module hbs_store (
	input  logic          clk,
	input  logic          wr_en,
	input  hbs_pkg::addr_t wr_addr,
	input  hbs_pkg::raw_t  wr_data,
	input  logic          rd_en,
	input  hbs_pkg::addr_t addr_a,
	input  hbs_pkg::addr_t addr_b,
	input  hbs_pkg::addr_t addr_c,
	input  hbs_pkg::addr_t addr_d,
	output hbs_pkg::raw_t  data_a,
	output hbs_pkg::raw_t  data_b,
	output hbs_pkg::raw_t  data_c,
	output hbs_pkg::raw_t  data_d
);
	import hbs_pkg::*;

	raw_t mem_lo_q [STORE_DEPTH];
	raw_t mem_hi_q [STORE_DEPTH];

	// both copies take every write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_lo_q[wr_addr] <= wr_data;
			mem_hi_q[wr_addr] <= wr_data;
		end
	end

	// lower row from one copy, upper row from the other
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_a <= mem_lo_q[addr_a];
			data_b <= mem_lo_q[addr_b];
			data_c <= mem_hi_q[addr_c];
			data_d <= mem_hi_q[addr_d];
		end
	end

endmodule

### rtl/heightmap_bilinear_sampler_top.sv
// heightmap bilinear sampler: apb registers, eight-stage query pipeline
// depends on hbs_pkg and hbs_store
//
// One request enters per cycle unless a result is held at the output. Each
// query leaves a result; loads leave none and write the store at the store read,
// in order with the reads of queries, so a query always sees every earlier load.
// The stages are: range check, coordinate scaling multiply, row stride multiply,
// address add and store bound check, store read, horizontal blend, vertical
// blend multiply, final round and bias. The whole pipeline holds while a result
// waits at the output. The store keeps two copies of the heightmap so the four
// neighbours are read together.
module heightmap_bilinear_sampler_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // load_index, raw_height, query_x, query_z
	input  logic        s_tuser,  // req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // height_value, query_status, zero fill
);
	import hbs_pkg::*;

	logic [10:0] map_w_q;
	logic [23:0] cells_q;
	logic [18:0] limit_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= MAP_WIDTH_RST;
			cells_q <= CELLS_RST;
			limit_q <= LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_MAP_WIDTH: map_w_q <= pwdata[10:0];
				REG_CELLS:     cells_q <= pwdata[23:0];
				REG_LIMIT:     limit_q <= pwdata[18:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_MAP_WIDTH: prdata = {21'd0, map_w_q};
			REG_CELLS:     prdata = {8'd0, cells_q};
			REG_LIMIT:     prdata = {13'd0, limit_q};
			default:       prdata = 32'd0;
		endcase
	end
	assign pready = 1'b1;

	// pipeline advance
	logic adv;
	logic v_s8;
	logic q_s8;
	assign adv      = !(v_s8 && q_s8) || m_tready;
	assign s_tready = adv;

	// stage 1: unpack and range check
	logic [COORD_W-1:0] qx_in, qz_in;
	logic               outside_in;
	assign qx_in = s_tdata[51:32];
	assign qz_in = s_tdata[71:52];
	assign outside_in = qx_in[COORD_W-1] || qz_in[COORD_W-1]
		|| (qx_in[18:0] > limit_q) || (qz_in[18:0] > limit_q);

	logic v_s1, q_s1, out_s1;
	logic [18:0] x_s1, z_s1;
	logic [15:0] lidx_s1;
	raw_t lraw_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1    <= (s_tuser == REQ_QUERY);
			out_s1  <= outside_in;
			x_s1    <= qx_in[18:0];
			z_s1    <= qz_in[18:0];
			lidx_s1 <= s_tdata[15:0];
			lraw_s1 <= s_tdata[31:16];
		end
	end

	// stage 2: scale to grid position
	logic [42:0] sx, sz;
	assign sx = 43'(x_s1) * 43'(cells_q);
	assign sz = 43'(z_s1) * 43'(cells_q);

	logic v_s2, q_s2, out_s2;
	logic [18:0] ix_s2, iz_s2;
	logic [15:0] u_s2, w_s2;
	logic [15:0] lidx_s2;
	raw_t lraw_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s2    <= q_s1;
			out_s2  <= out_s1;
			ix_s2   <= sx[42:24];
			iz_s2   <= sz[42:24];
			u_s2    <= sx[23:8];
			w_s2    <= sz[23:8];
			lidx_s2 <= lidx_s1;
			lraw_s2 <= lraw_s1;
		end
	end

	// stage 3: row offset
	logic v_s3, q_s3, out_s3;
	logic [29:0] rowoff_s3;
	logic [18:0] ix_s3;
	logic [15:0] u_s3, w_s3;
	logic [15:0] lidx_s3;
	raw_t lraw_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s3      <= q_s2;
			out_s3    <= out_s2;
			rowoff_s3 <= 30'(map_w_q) * 30'(iz_s2);
			ix_s3     <= ix_s2;
			u_s3      <= u_s2;
			w_s3      <= w_s2;
			lidx_s3   <= lidx_s2;
			lraw_s3   <= lraw_s2;
		end
	end

	// stage 4: base address and bound on the farthest neighbour
	logic [31:0] base_full, top_full;
	logic        beyond_in;
	assign base_full = 32'(rowoff_s3) + 32'(ix_s3);
	assign top_full  = base_full + 32'(map_w_q) + 32'd1;
	assign beyond_in = (top_full >= 32'(STORE_DEPTH));

	logic v_s4, q_s4;
	logic [1:0] st_s4;
	addr_t base_s4;
	logic [15:0] u_s4, w_s4;
	logic [15:0] lidx_s4;
	raw_t lraw_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4    <= q_s3;
			st_s4   <= out_s3 ? ST_OUTSIDE : (beyond_in ? ST_BEYOND : ST_OK);
			base_s4 <= ADDR_W'(base_full);
			u_s4    <= u_s3;
			w_s4    <= w_s3;
			lidx_s4 <= lidx_s3;
			lraw_s4 <= lraw_s3;
		end
	end

	// stage 5: store access, loads write in request order
	logic  st_wr_en;
	addr_t addr_b, addr_c, addr_d;
	raw_t  a_s5, b_s5, c_s5, d_s5;
	assign st_wr_en = adv && v_s4 && !q_s4 && (32'(lidx_s4) < 32'(STORE_DEPTH));
	assign addr_b   = base_s4 + addr_t'(1);
	assign addr_c   = base_s4 + ADDR_W'(map_w_q);
	assign addr_d   = addr_c + addr_t'(1);

	hbs_store u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (ADDR_W'(lidx_s4)),
		.wr_data (lraw_s4),
		.rd_en   (adv),
		.addr_a  (base_s4),
		.addr_b  (addr_b),
		.addr_c  (addr_c),
		.addr_d  (addr_d),
		.data_a  (a_s5),
		.data_b  (b_s5),
		.data_c  (c_s5),
		.data_d  (d_s5)
	);

	logic v_s5, q_s5;
	logic [1:0] st_s5;
	logic [15:0] u_s5, w_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s5  <= q_s4;
			st_s5 <= st_s4;
			u_s5  <= u_s4;
			w_s5  <= w_s4;
		end
	end

	// stage 6: blend along x, row = a*2^16 + (b - a)*u
	logic signed [16:0] dab, dcd;
	logic signed [33:0] prod_ab, prod_cd, row0_full, row1_full;
	assign dab       = $signed({1'b0, b_s5}) - $signed({1'b0, a_s5});
	assign dcd       = $signed({1'b0, d_s5}) - $signed({1'b0, c_s5});
	assign prod_ab   = 34'(dab * $signed({1'b0, u_s5}));
	assign prod_cd   = 34'(dcd * $signed({1'b0, u_s5}));
	assign row0_full = $signed({2'b00, a_s5, 16'd0}) + prod_ab;
	assign row1_full = $signed({2'b00, c_s5, 16'd0}) + prod_cd;

	logic v_s6, q_s6;
	logic [1:0] st_s6;
	logic [31:0] row0_s6, row1_s6;
	logic [15:0] w_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s6    <= q_s5;
			st_s6   <= st_s5;
			row0_s6 <= row0_full[31:0];
			row1_s6 <= row1_full[31:0];
			w_s6    <= w_s5;
		end
	end

	// stage 7: vertical difference times w
	logic signed [32:0] drow;
	assign drow = $signed({1'b0, row1_s6}) - $signed({1'b0, row0_s6});

	logic v_s7, q_s7;
	logic [1:0] st_s7;
	logic signed [49:0] pv_s7;
	logic [31:0] row0_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s7    <= q_s6;
			st_s7   <= st_s6;
			pv_s7   <= 50'(drow * $signed({1'b0, w_s6}));
			row0_s7 <= row0_s6;
		end
	end

	// stage 8: mix, round half up to raw*256 units, remove bias
	logic signed [50:0] mix_full;
	logic [HGT_W-1:0]   rounded, height_in;
	assign mix_full  = $signed({3'b000, row0_s7, 16'd0}) + 51'(pv_s7)
		+ $signed(51'd8388608);
	assign rounded   = mix_full[48:24];
	assign height_in = (st_s7 == ST_OK) ? (rounded - HEIGHT_BIAS) : '0;

	logic [1:0] st_s8;
	logic [HGT_W-1:0] height_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s8      <= q_s7;
			st_s8     <= st_s7;
			height_s8 <= height_in;
		end
	end

	assign m_tvalid = v_s8 && q_s8;
	assign m_tdata  = {5'd0, st_s8, height_s8};

	// a failed query carries zero height
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && st_s8 != ST_OK) |-> (height_s8 == '0))
		else $error("failed query with nonzero height");

	// a store write only ever comes from a load request
	a_write_load: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr_en |-> (v_s4 && !q_s4 && !(m_tvalid && !m_tready)))
		else $error("store write outside a load request");

	// a held pipeline keeps its read stage and output stage occupancy
	a_hold_read: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (v_s5 == $past(v_s5)) && (v_s8 == $past(v_s8)))
		else $error("pipeline moved while held");

endmodule
